// ----- rtl/dedup_message_id_store_top_defines.svh -----
// Assertion macros shared by the message ID store RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef DEDUP_MESSAGE_ID_STORE_TOP_DEFINES_SVH
`define DEDUP_MESSAGE_ID_STORE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DMIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dmis_pkg.sv -----
// Shared types and codes for the message ID store.
// No dependencies; imported by the store, the sequencer and the top level.
package dmis_pkg;

	localparam int ID_W     = 256;
	localparam int HANDLE_W = 32;
	localparam int LIMIT_W  = 7;
	localparam int COUNT_W  = 7;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_MARK = 2'd1;
	localparam logic [1:0] OP_LIST = 2'd2;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_DUP       = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	typedef logic [ID_W-1:0] id_t;

	typedef struct packed {
		id_t                 id;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic [1:0]         operation;
		id_t                id;
		logic [HANDLE_W-1:0] handle;
		logic               initial_read;
		logic [LIMIT_W-1:0] list_limit;
		logic               unread_filter;
	} cmd_t;

	typedef struct packed {
		logic rd_en;
		logic entry_en;
		logic flag_en;
		logic flag;
	} store_ctl_t;

	typedef struct packed {
		logic                valid;
		logic [1:0]          status;
		logic                entry_valid;
		id_t                 id;
		logic [HANDLE_W-1:0] handle;
		logic                read;
		logic                last;
		logic [COUNT_W-1:0]  stored_count;
	} result_t;

endpackage

// ----- rtl/dmis_store.sv -----
// Entry memory (ID and handle) and read-flag memory with registered read data.
// Depends on dmis_pkg for the entry and control types.
module dmis_store import dmis_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  store_ctl_t    ctl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_entry,
	output entry_t        rd_entry,
	output logic          rd_flag
);

	entry_t mem_entry_q [DEPTH];
	logic   mem_flag_q  [DEPTH];
	entry_t rd_entry_q;
	logic   rd_flag_q;

	always_ff @(posedge clk) begin
		if (ctl.entry_en) begin
			mem_entry_q[wr_addr] <= wr_entry;
		end
		if (ctl.flag_en) begin
			mem_flag_q[wr_addr] <= ctl.flag;
		end
		if (ctl.rd_en) begin
			rd_entry_q <= mem_entry_q[rd_addr];
			rd_flag_q  <= mem_flag_q[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_flag  = rd_flag_q;

endmodule

// ----- rtl/dmis_ctrl.sv -----
// Scan sequencer: walks the circular entry table one slot a cycle through the
// shared ID comparator, and drives the result registers. Depends on dmis_pkg.
`include "dedup_message_id_store_top_defines.svh"

module dmis_ctrl import dmis_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cmd_t          cmd,
	output logic          busy,
	output store_ctl_t    store_ctl,
	output logic [AW-1:0] rd_addr,
	output logic [AW-1:0] wr_addr,
	output entry_t        wr_entry,
	input  entry_t        rd_entry,
	input  logic          rd_flag,
	output result_t       result
);

	localparam int SW = AW + 1;

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_SCAN = 1'b1;

	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_RD   = 2'd1;
	localparam logic [1:0] SRC_HELD = 2'd2;

	// Logical slot to physical address; slot 0 is the oldest entry at head.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	logic [0:0]          state_q;
	logic [1:0]          op_q;
	id_t                 id_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                init_q;
	logic [LIMIT_W-1:0]  lim_q;
	logic                unread_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       idx_q;
	logic                iss_q;
	logic                vld_s1;
	logic [AW-1:0]       phys_s1;
	logic [CW-1:0]       n_q;
	logic                held_q;
	entry_t              held_entry_q;
	logic                held_flag_q;
	result_t             res_q;

	logic [LIMIT_W-1:0] lim_eff;
	logic               is_find;
	logic               list_op;
	logic               hit;
	logic               keep;
	logic               at_limit;
	logic               scan_end;
	logic [AW-1:0]      add_addr;
	logic [AW-1:0]      head_inc;
	logic               stop;
	logic               emit;
	logic               emit_last;
	logic [1:0]         emit_status;
	logic [1:0]         emit_src;
	logic               hold;
	logic               entry_wr;
	logic               flag_wr;
	logic               flag_val;
	logic [CW-1:0]      count_d;
	logic [AW-1:0]      head_d;

	assign lim_eff  = (cmd.list_limit > LIMIT_W'(DEPTH)) ? LIMIT_W'(DEPTH) : cmd.list_limit;
	assign is_find  = (op_q == OP_ADD) || (op_q == OP_MARK);
	assign list_op  = (op_q == OP_LIST);
	// Shared comparator: one stored ID against the command ID per cycle.
	assign hit      = vld_s1 && (rd_entry.id == id_q);
	assign keep     = vld_s1 && !(unread_q && rd_flag);
	assign at_limit = held_q && (LIMIT_W'(n_q) == lim_q);
	assign scan_end = (state_q == ST_SCAN) && !iss_q && !vld_s1;
	assign rd_addr  = phys(head_q, idx_q);
	assign add_addr = phys(head_q, count_q);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	always_comb begin
		stop        = 1'b0;
		emit        = 1'b0;
		emit_last   = 1'b1;
		emit_status = STATUS_DONE;
		emit_src    = SRC_NONE;
		hold        = 1'b0;
		entry_wr    = 1'b0;
		flag_wr     = 1'b0;
		flag_val    = 1'b1;
		count_d     = count_q;
		head_d      = head_q;
		wr_addr     = phys_s1;
		if (state_q == ST_SCAN) begin
			if (is_find && hit) begin
				stop = 1'b1;
				emit = 1'b1;
				if (op_q == OP_ADD) begin
					emit_status = STATUS_DUP;
				end else begin
					flag_wr = 1'b1;
				end
			end else if (list_op && at_limit) begin
				// Once the limit is reached, the held candidate is the final result.
				stop     = 1'b1;
				emit     = 1'b1;
				emit_src = SRC_HELD;
			end else if (list_op && keep) begin
				// The previous candidate goes out only once a later one shows
				// it is not the final result.
				hold = 1'b1;
				if (held_q) begin
					emit      = 1'b1;
					emit_last = 1'b0;
					emit_src  = SRC_HELD;
				end
			end else if (scan_end) begin
				stop = 1'b1;
				emit = 1'b1;
				case (op_q)
					OP_ADD: begin
						entry_wr = 1'b1;
						flag_wr  = 1'b1;
						flag_val = init_q;
						wr_addr  = add_addr;
						// A full table overwrites the oldest slot and moves head on.
						if (count_q == CW'(DEPTH)) begin
							head_d = head_inc;
						end else begin
							count_d = count_q + CW'(1);
						end
					end
					OP_MARK: begin
						emit_status = STATUS_NOT_FOUND;
					end
					OP_LIST: begin
						if (held_q) begin
							emit_src = SRC_HELD;
						end
					end
					default: begin
						emit_status = STATUS_DONE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			head_q    <= '0;
			iss_q     <= 1'b0;
			vld_s1    <= 1'b0;
			held_q    <= 1'b0;
			n_q       <= '0;
			res_q     <= '0;
		end else begin
			res_q.valid <= emit;
			count_q     <= count_d;
			head_q      <= head_d;
			if (state_q == ST_IDLE) begin
				vld_s1 <= 1'b0;
				if (start) begin
					state_q <= ST_SCAN;
					held_q  <= 1'b0;
					n_q     <= '0;
					if (cmd.operation == OP_LIST) begin
						iss_q <= (count_q != '0) && (lim_eff != '0);
					end else if ((cmd.operation == OP_ADD) || (cmd.operation == OP_MARK)) begin
						iss_q <= (count_q != '0);
					end else begin
						iss_q <= 1'b0;
					end
				end
			end else begin
				vld_s1 <= iss_q && !stop;
				if (stop) begin
					state_q <= ST_IDLE;
					iss_q   <= 1'b0;
				end else if (iss_q) begin
					if (list_op) begin
						iss_q <= (idx_q != '0);
					end else begin
						iss_q <= (idx_q != count_q - CW'(1));
					end
				end
				if (hold) begin
					held_q <= 1'b1;
					n_q    <= n_q + CW'(1);
				end
			end
			if (emit) begin
				res_q.status       <= emit_status;
				res_q.entry_valid  <= (emit_src != SRC_NONE);
				res_q.last         <= emit_last;
				res_q.stored_count <= COUNT_W'(count_d);
				case (emit_src)
					SRC_RD: begin
						res_q.id     <= rd_entry.id;
						res_q.handle <= rd_entry.handle;
						res_q.read   <= rd_flag;
					end
					SRC_HELD: begin
						res_q.id     <= held_entry_q.id;
						res_q.handle <= held_entry_q.handle;
						res_q.read   <= held_flag_q;
					end
					default: begin
						res_q.id     <= '0;
						res_q.handle <= '0;
						res_q.read   <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			op_q     <= cmd.operation;
			id_q     <= cmd.id;
			handle_q <= cmd.handle;
			init_q   <= cmd.initial_read;
			lim_q    <= lim_eff;
			unread_q <= cmd.unread_filter;
			idx_q    <= (cmd.operation == OP_LIST) ? count_q - CW'(1) : '0;
		end else if ((state_q == ST_SCAN) && iss_q) begin
			idx_q <= list_op ? idx_q - CW'(1) : idx_q + CW'(1);
		end
		phys_s1 <= rd_addr;
		if (hold) begin
			held_entry_q <= rd_entry;
			held_flag_q  <= rd_flag;
		end
	end

	assign busy               = (state_q != ST_IDLE);
	assign store_ctl.rd_en    = (state_q == ST_SCAN) && iss_q;
	assign store_ctl.entry_en = entry_wr;
	assign store_ctl.flag_en  = flag_wr;
	assign store_ctl.flag     = flag_val;
	assign wr_entry.id        = id_q;
	assign wr_entry.handle    = handle_q;
	assign result             = res_q;

	`DMIS_ASSERT_NEXT(a_start_scans, clk, arst_n, start && (state_q == ST_IDLE), state_q == ST_SCAN, "accepted transaction did not start a scan")
	`DMIS_ASSERT_NEXT(a_stop_idle, clk, arst_n, stop, (state_q == ST_IDLE) && !vld_s1 && res_q.valid, "scan stop did not return to idle with a result")
	`DMIS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "entry count above table depth")
	`DMIS_ASSERT_NOW(a_pipe_in_scan, clk, arst_n, vld_s1 || iss_q, state_q == ST_SCAN, "read pipeline active outside a scan")
	`DMIS_ASSERT_NOW(a_held_list, clk, arst_n, held_q && (state_q == ST_SCAN), list_op, "held candidate outside a list transaction")

endmodule

// ----- rtl/dedup_message_id_store_top.sv -----
// Top level of the message ID store: command and result ports.
// Depends on dmis_pkg, dmis_store and dmis_ctrl.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   operation 0 adds an ID (rejected as a duplicate if already stored, else the
//   oldest entry is evicted when full), 1 marks an ID read, 2 lists entries
//   newest first, up to list_limit, optionally unread ones only.
//   Each result appears for one cycle with result_valid high; last marks the
//   final one. The receiver cannot stall, so results are never held back.
//   Timing: the sequencer reads one stored slot per cycle from the entry
//   memory and checks it in the shared ID comparator. An add or mark-read
//   scans the stored entries, and its result is on the ports in the first
//   cycle with busy low; a match ends the scan early. A list streams its
//   results during the scan, and its final result also comes in the first
//   cycle with busy low.
//   Reset empties the table at once (count and head cleared); no clearing
//   pass runs, and busy is low right after reset.
module dedup_message_id_store_top import dmis_pkg::*; #(
	parameter int STORE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          operation,
	input  logic [63:0]         id_word0,
	input  logic [63:0]         id_word1,
	input  logic [63:0]         id_word2,
	input  logic [63:0]         id_word3,
	input  logic [HANDLE_W-1:0] record_handle,
	input  logic                initial_read,
	input  logic [LIMIT_W-1:0]  list_limit,
	input  logic                unread_filter,
	output logic                result_valid,
	output logic [1:0]          status,
	output logic                entry_valid,
	output logic [63:0]         out_id_word0,
	output logic [63:0]         out_id_word1,
	output logic [63:0]         out_id_word2,
	output logic [63:0]         out_id_word3,
	output logic [HANDLE_W-1:0] out_handle,
	output logic                out_read,
	output logic                last,
	output logic [COUNT_W-1:0]  stored_count
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);

	cmd_t          cmd;
	store_ctl_t    store_ctl;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	entry_t        rd_entry;
	logic          rd_flag;
	result_t       result;

	assign cmd.operation     = operation;
	assign cmd.id            = {id_word3, id_word2, id_word1, id_word0};
	assign cmd.handle        = record_handle;
	assign cmd.initial_read  = initial_read;
	assign cmd.list_limit    = list_limit;
	assign cmd.unread_filter = unread_filter;

	dmis_ctrl #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.store_ctl (store_ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_entry  (wr_entry),
		.rd_entry  (rd_entry),
		.rd_flag   (rd_flag),
		.result    (result)
	);

	dmis_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.ctl      (store_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry),
		.rd_flag  (rd_flag)
	);

	assign result_valid = result.valid;
	assign status       = result.status;
	assign entry_valid  = result.entry_valid;
	assign out_id_word0 = result.id[63:0];
	assign out_id_word1 = result.id[127:64];
	assign out_id_word2 = result.id[191:128];
	assign out_id_word3 = result.id[255:192];
	assign out_handle   = result.handle;
	assign out_read     = result.read;
	assign last         = result.last;
	assign stored_count = result.stored_count;

endmodule

// ----- tb/dedup_message_id_store_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the message ID store: a queue-fed command driver, a result monitor
// and a table predictor that mirrors add, mark-read and list. Depends on dmis_pkg and the top.
module dedup_message_id_store_top_tb import dmis_pkg::*; ();

	localparam int         TBL_DEPTH   = 64;
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         STALL_LIMIT = 4000;
	localparam int         DRAIN_WAIT  = TBL_DEPTH + 8;
	localparam int         RAND_ITEMS  = 325;

	typedef struct {
		logic [1:0]          op;
		logic [ID_W-1:0]     id;
		logic [HANDLE_W-1:0] handle;
		logic                init_rd;
		logic [LIMIT_W-1:0]  limit;
		logic                unread;
		int                  gap_pct;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]          status;
		logic                entry_valid;
		logic [ID_W-1:0]     id;
		logic [HANDLE_W-1:0] handle;
		logic                rd;
		logic                last;
		logic [COUNT_W-1:0]  count;
	} reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [1:0]          operation = OP_ADD;
	logic [63:0]         id_word0 = '0;
	logic [63:0]         id_word1 = '0;
	logic [63:0]         id_word2 = '0;
	logic [63:0]         id_word3 = '0;
	logic [HANDLE_W-1:0] record_handle = '0;
	logic                initial_read = 1'b0;
	logic [LIMIT_W-1:0]  list_limit = '0;
	logic                unread_filter = 1'b0;
	logic                busy;
	logic                result_valid;
	logic [1:0]          status;
	logic                entry_valid;
	logic [63:0]         out_id_word0;
	logic [63:0]         out_id_word1;
	logic [63:0]         out_id_word2;
	logic [63:0]         out_id_word3;
	logic [HANDLE_W-1:0] out_handle;
	logic                out_read;
	logic                last;
	logic [COUNT_W-1:0]  stored_count;

	dedup_message_id_store_top #(.STORE_DEPTH(TBL_DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation),
		.id_word0(id_word0), .id_word1(id_word1), .id_word2(id_word2), .id_word3(id_word3),
		.record_handle(record_handle), .initial_read(initial_read),
		.list_limit(list_limit), .unread_filter(unread_filter),
		.result_valid(result_valid), .status(status), .entry_valid(entry_valid),
		.out_id_word0(out_id_word0), .out_id_word1(out_id_word1),
		.out_id_word2(out_id_word2), .out_id_word3(out_id_word3),
		.out_handle(out_handle), .out_read(out_read), .last(last),
		.stored_count(stored_count)
	);

	// Shadow copy of the table, slot 0 the oldest entry.
	logic [ID_W-1:0]     tbl_id [TBL_DEPTH];
	logic [HANDLE_W-1:0] tbl_handle [TBL_DEPTH];
	logic                tbl_read [TBL_DEPTH];
	int                  tbl_held = 0;

	cmd_item_t       cmd_backlog[$];
	cmd_item_t       cur_cmd;
	reply_t          due_replies[$];
	logic [ID_W-1:0] id_pool[$];

	int cmds_taken = 0;
	int replies_seen = 0;
	int entries_listed = 0;
	int evictions = 0;
	int dup_rejects = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic reply_t plain_reply(logic [1:0] st);
		reply_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		r.count = COUNT_W'(tbl_held);
		return r;
	endfunction

	function automatic string reply_text(reply_t r);
		return $sformatf("st=%0d ev=%0d id=%h hd=%h rd=%0d last=%0d cnt=%0d",
			r.status, r.entry_valid, r.id, r.handle, r.rd, r.last, r.count);
	endfunction

	// Applies one accepted transaction to the shadow table and queues the replies it causes.
	task automatic table_apply(cmd_item_t c);
		int     hit;
		int     lim;
		int     picked[$];
		reply_t r;
		hit = -1;
		for (int i = 0; i < tbl_held; i++) begin
			if (hit < 0 && tbl_id[i] == c.id) begin
				hit = i;
			end
		end
		case (c.op)
			OP_ADD: begin
				if (hit >= 0) begin
					dup_rejects++;
					due_replies.push_back(plain_reply(STATUS_DUP));
				end else begin
					if (tbl_held == TBL_DEPTH) begin
						for (int i = 0; i < TBL_DEPTH - 1; i++) begin
							tbl_id[i] = tbl_id[i+1];
							tbl_handle[i] = tbl_handle[i+1];
							tbl_read[i] = tbl_read[i+1];
						end
						tbl_held = TBL_DEPTH - 1;
						evictions++;
					end
					tbl_id[tbl_held] = c.id;
					tbl_handle[tbl_held] = c.handle;
					tbl_read[tbl_held] = c.init_rd;
					tbl_held++;
					due_replies.push_back(plain_reply(STATUS_DONE));
				end
			end
			OP_MARK: begin
				if (hit < 0) begin
					due_replies.push_back(plain_reply(STATUS_NOT_FOUND));
				end else begin
					tbl_read[hit] = 1'b1;
					due_replies.push_back(plain_reply(STATUS_DONE));
				end
			end
			OP_LIST: begin
				lim = (c.limit > TBL_DEPTH) ? TBL_DEPTH : int'(c.limit);
				for (int i = tbl_held - 1; i >= 0 && picked.size() < lim; i--) begin
					if (!(c.unread && tbl_read[i])) begin
						picked.push_back(i);
					end
				end
				if (picked.size() == 0) begin
					due_replies.push_back(plain_reply(STATUS_DONE));
				end
				foreach (picked[k]) begin
					r = plain_reply(STATUS_DONE);
					r.entry_valid = 1'b1;
					r.id = tbl_id[picked[k]];
					r.handle = tbl_handle[picked[k]];
					r.rd = tbl_read[picked[k]];
					r.last = (k == picked.size() - 1);
					due_replies.push_back(r);
					entries_listed++;
				end
			end
			default: begin
				due_replies.push_back(plain_reply(STATUS_DONE));
			end
		endcase
	endtask

	// Command driver: a transaction completes on an edge with start high and busy low.
	always @(posedge clk) begin
		cmd_item_t nxt;
		logic      taken;
		if (arst_n) begin
			taken = start && !busy;
			if (taken) begin
				table_apply(cur_cmd);
				cmds_taken++;
			end
			if (taken || !start) begin
				if (cmd_backlog.size() != 0 &&
						$urandom_range(99) >= cmd_backlog[0].gap_pct) begin
					nxt = cmd_backlog.pop_front();
					cur_cmd = nxt;
					operation <= nxt.op;
					id_word0 <= nxt.id[63:0];
					id_word1 <= nxt.id[127:64];
					id_word2 <= nxt.id[191:128];
					id_word3 <= nxt.id[255:192];
					record_handle <= nxt.handle;
					initial_read <= nxt.init_rd;
					list_limit <= nxt.limit;
					unread_filter <= nxt.unread;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every strobed result is checked against the oldest pending reply.
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && result_valid) begin
			got = {status, entry_valid, out_id_word3, out_id_word2, out_id_word1, out_id_word0,
				out_handle, out_read, last, stored_count};
			replies_seen++;
			if (due_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("[%0t] unexpected result: %s", $realtime, reply_text(got));
				end
			end else begin
				want = due_replies.pop_front();
				if (got.status !== want.status || got.entry_valid !== want.entry_valid ||
						got.id !== want.id || got.handle !== want.handle ||
						got.rd !== want.rd || got.last !== want.last ||
						got.count !== want.count) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("[%0t] result mismatch\n  expected %s\n  actual   %s",
							$realtime, reply_text(want), reply_text(got));
					end
				end
			end
		end
	end

	// Watchdog on cycles in which neither a command nor a result is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles == STALL_LIMIT) begin
				$display("timeout after %0d quiet cycles", STALL_LIMIT);
				$display("dedup_message_id_store_top_tb: errors");
				$finish;
			end
		end
	end

	function automatic logic [ID_W-1:0] random_id();
		return {$urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	// Picks one of the recently added IDs; old ones may already be evicted.
	function automatic logic [ID_W-1:0] recent_id();
		int span;
		if (id_pool.size() == 0) begin
			return random_id();
		end
		span = (id_pool.size() > 80) ? 80 : id_pool.size();
		return id_pool[id_pool.size() - 1 - $urandom_range(span - 1)];
	endfunction

	task automatic queue_cmd(logic [1:0] op, logic [ID_W-1:0] id, logic [HANDLE_W-1:0] handle,
			logic init_rd, logic [LIMIT_W-1:0] limit, logic unread, int gap_pct);
		cmd_item_t c;
		c.op = op;
		c.id = id;
		c.handle = handle;
		c.init_rd = init_rd;
		c.limit = limit;
		c.unread = unread;
		c.gap_pct = gap_pct;
		cmd_backlog.push_back(c);
		if (op == OP_ADD) begin
			id_pool.push_back(id);
		end
	endtask

	initial begin
		logic [ID_W-1:0]    ones;
		logic [ID_W-1:0]    id;
		logic [LIMIT_W-1:0] limit;
		int                 gaps[4];
		int                 pick;
		int                 gap;
		ones = '1;
		gaps = '{0, 47, 0, 32};

		// Directed part: empty table, field extremes, near-miss IDs and list limits.
		queue_cmd(OP_LIST, '0, '0, 1'b0, 7'd64, 1'b0, 0);
		queue_cmd(OP_MARK, ones, '0, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_UNUSED, '0, '0, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_ADD, '0, '0, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_ADD, ones, '1, 1'b1, '1, 1'b1, 0);
		queue_cmd(OP_ADD, ones, 32'h1234_5678, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_ADD, {1'b0, ones[ID_W-2:0]}, 32'h5a5a_5a5a, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_ADD, {{(ID_W-1){1'b0}}, 1'b1}, 32'ha5a5_a5a5, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_ADD, {64'd3, 64'd2, 64'd1, 64'd0}, 32'h0000_0001, 1'b1, '0, 1'b0, 0);
		queue_cmd(OP_MARK, '0, '0, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_MARK, '0, '1, 1'b1, '1, 1'b1, 0);
		queue_cmd(OP_MARK, {64'd0, 64'd1, 64'd2, 64'd3}, '0, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_LIST, '0, '0, 1'b0, 7'd0, 1'b0, 0);
		queue_cmd(OP_LIST, '0, '0, 1'b0, 7'd1, 1'b0, 0);
		queue_cmd(OP_LIST, '0, '0, 1'b0, 7'd127, 1'b0, 0);
		queue_cmd(OP_LIST, '0, '0, 1'b0, 7'd64, 1'b1, 0);
		queue_cmd(OP_LIST, ones, '1, 1'b1, 7'd2, 1'b0, 0);
		queue_cmd(OP_LIST, '0, '0, 1'b0, 7'd65, 1'b1, 0);
		queue_cmd(OP_UNUSED, ones, '1, 1'b1, '1, 1'b1, 0);
		queue_cmd(OP_MARK, ones, '0, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_MARK, {1'b0, ones[ID_W-2:0]}, '0, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_MARK, {{(ID_W-1){1'b0}}, 1'b1}, '0, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_MARK, {64'd3, 64'd2, 64'd1, 64'd0}, '0, 1'b0, '0, 1'b0, 0);
		queue_cmd(OP_LIST, '0, '0, 1'b0, 7'd64, 1'b1, 0);
		queue_cmd(OP_LIST, '0, '0, 1'b0, 7'd3, 1'b0, 0);

		// Random part: enough fresh adds to wrap the table more than once, mixed with
		// duplicates, mark-reads of live, evicted and near-miss IDs, and lists.
		for (int i = 0; i < RAND_ITEMS; i++) begin
			gap = gaps[(i * 4) / RAND_ITEMS];
			pick = $urandom_range(99);
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: limit = LIMIT_W'($urandom_range(12));
				6, 7: limit = LIMIT_W'($urandom_range(13, 63));
				8: limit = LIMIT_W'(TBL_DEPTH);
				default: limit = LIMIT_W'($urandom_range(65, 127));
			endcase
			if (pick < 42) begin
				id = random_id();
				queue_cmd(OP_ADD, id, $urandom(), 1'($urandom()), limit, 1'($urandom()), gap);
			end else if (pick < 52) begin
				id = recent_id();
				queue_cmd(OP_ADD, id, $urandom(), 1'($urandom()), limit, 1'($urandom()), gap);
			end else if (pick < 67) begin
				id = recent_id();
				queue_cmd(OP_MARK, id, $urandom(), 1'($urandom()), limit, 1'($urandom()), gap);
			end else if (pick < 74) begin
				id = recent_id() ^ (256'd1 << $urandom_range(ID_W - 1));
				queue_cmd(OP_MARK, id, $urandom(), 1'($urandom()), limit, 1'($urandom()), gap);
			end else if (pick < 97) begin
				id = random_id();
				queue_cmd(OP_LIST, id, $urandom(), 1'($urandom()), limit, 1'($urandom()), gap);
			end else begin
				id = random_id();
				queue_cmd(OP_UNUSED, id, $urandom(), 1'($urandom()), limit, 1'($urandom()), gap);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start || due_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		if (due_replies.size() != 0) begin
			mismatch_count++;
			$display("%0d results never arrived", due_replies.size());
		end
		$display("Ran %0d commands through the table: %0d results, %0d listed entries,",
			cmds_taken, replies_seen, entries_listed);
		$display("%0d evictions of the oldest entry, %0d duplicate rejects, %0d mismatches.",
			evictions, dup_rejects, mismatch_count);
		if (mismatch_count == 0) begin
			$display("dedup_message_id_store_top_tb: clean");
		end else begin
			$display("dedup_message_id_store_top_tb: errors");
		end
		$finish;
	end

endmodule
